[rtl/dsre_pkg.sv]
// dsre_pkg: shared constants, operation codes and ring index helpers
// for the two-stack rotate engine; no dependencies
package dsre_pkg;

	localparam int DEPTH = 512;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int DW    = 32;
	localparam int FW    = 4;

	typedef enum logic [FW-1:0] {
		OP_SA   = 4'd0,
		OP_SB   = 4'd1,
		OP_SS   = 4'd2,
		OP_PA   = 4'd3,
		OP_PB   = 4'd4,
		OP_RA   = 4'd5,
		OP_RB   = 4'd6,
		OP_RR   = 4'd7,
		OP_RRA  = 4'd8,
		OP_RRB  = 4'd9,
		OP_RRR  = 4'd10,
		OP_LOAD = 4'd11
	} op_t;

	// (base + k) mod DEPTH, base below DEPTH and k at most DEPTH
	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
			input logic [CW-1:0] k);
		logic [CW:0] s;
		s = {{(CW+1-AW){1'b0}}, base} + {1'b0, k};
		if (s >= (CW+1)'(DEPTH))
			s = s - (CW+1)'(DEPTH);
		return s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] base);
		return (base == '0) ? AW'(DEPTH - 1) : base - AW'(1);
	endfunction

endpackage

[rtl/dsre_ram.sv]
// dsre_ram: generic simple dual-port ram, one write and one registered read
// no package dependencies
module dsre_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

[rtl/dual_stack_rotate_engine.sv]
// dual_stack_rotate_engine: two ring stacks in rams with cached top entries
// depends on dsre_pkg and dsre_ram
//
//   channel  signals                            direction
//   in       in_valid, in_ready, func, value    word into the engine
//   out      out_valid, out_ready, performed,   word out of the engine
//            size_a, size_b, top_a, top_b
//
// each word does one ram read per stack on accept, then write-back and state
// update through the ram ports once the output register is free or drained.
// reset clears heads, counts and the pipeline; ram contents are not cleared.
// a stalled output holds the executing word; a new word is accepted as soon
// as the execute slot is free, even while a result waits on the output.
module dual_stack_rotate_engine
	import dsre_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [FW-1:0]        func,
	input  logic signed [DW-1:0] value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 performed,
	output logic [CW-1:0]        size_a,
	output logic [CW-1:0]        size_b,
	output logic signed [DW-1:0] top_a,
	output logic signed [DW-1:0] top_b
);

	logic                 pend_q;
	logic [FW-1:0]        func_s1;
	logic signed [DW-1:0] value_s1;
	logic [AW-1:0]        head_a_q, head_b_q;
	logic [CW-1:0]        count_a_q, count_b_q;
	logic signed [DW-1:0] tcache_a_q, tcache_b_q;
	logic                 out_valid_q, performed_q;
	logic [CW-1:0]        size_a_q, size_b_q;
	logic signed [DW-1:0] top_a_q, top_b_q;

	logic                 accept, exec;
	logic [AW-1:0]        raddr_a, raddr_b;
	logic [DW-1:0]        rdata_a, rdata_b;
	logic                 we_a, we_b;
	logic [AW-1:0]        waddr_a, waddr_b;
	logic [DW-1:0]        wdata_a, wdata_b;
	logic [AW-1:0]        head_a_d, head_b_d;
	logic [CW-1:0]        count_a_d, count_b_d;
	logic signed [DW-1:0] tcache_a_d, tcache_b_d;
	logic                 pa, pb;
	logic                 two_a, two_b;

	assign in_ready = !pend_q;
	assign accept   = in_valid && in_ready;
	assign exec     = pend_q && (!out_valid_q || out_ready);

	// read addresses: bottom entry for reverse rotate, second entry otherwise
	always_comb begin
		raddr_a = ring_add(head_a_q, CW'(1));
		raddr_b = ring_add(head_b_q, CW'(1));
		if (func == OP_RRA || func == OP_RRR)
			raddr_a = ring_add(head_a_q, (count_a_q == '0) ? '0 : count_a_q - CW'(1));
		if (func == OP_RRB || func == OP_RRR)
			raddr_b = ring_add(head_b_q, (count_b_q == '0) ? '0 : count_b_q - CW'(1));
	end

	dsre_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr_a),
		.wdata (wdata_a),
		.re    (accept),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	dsre_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr_b),
		.wdata (wdata_b),
		.re    (accept),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	// execute: write-back and next state
	// the ram entry at the head is never trusted, the cached top is
	always_comb begin
		two_a      = count_a_q >= CW'(2);
		two_b      = count_b_q >= CW'(2);
		head_a_d   = head_a_q;
		head_b_d   = head_b_q;
		count_a_d  = count_a_q;
		count_b_d  = count_b_q;
		tcache_a_d = tcache_a_q;
		tcache_b_d = tcache_b_q;
		we_a       = 1'b0;
		we_b       = 1'b0;
		waddr_a    = ring_add(head_a_q, CW'(1));
		waddr_b    = ring_add(head_b_q, CW'(1));
		wdata_a    = tcache_a_q;
		wdata_b    = tcache_b_q;
		pa         = 1'b0;
		pb         = 1'b0;
		case (func_s1)
			OP_SA, OP_SS, OP_SB: begin
				if ((func_s1 == OP_SA || func_s1 == OP_SS) && two_a) begin
					we_a       = 1'b1;
					tcache_a_d = $signed(rdata_a);
					pa         = 1'b1;
				end
				if ((func_s1 == OP_SB || func_s1 == OP_SS) && two_b) begin
					we_b       = 1'b1;
					tcache_b_d = $signed(rdata_b);
					pb         = 1'b1;
				end
			end
			OP_PA: begin
				if (count_b_q != '0 && count_a_q != CW'(DEPTH)) begin
					head_b_d   = ring_add(head_b_q, CW'(1));
					count_b_d  = count_b_q - CW'(1);
					tcache_b_d = $signed(rdata_b);
					head_a_d   = ring_dec(head_a_q);
					count_a_d  = count_a_q + CW'(1);
					tcache_a_d = tcache_b_q;
					we_a       = 1'b1;
					waddr_a    = head_a_q;
					wdata_a    = tcache_a_q;
					pa         = 1'b1;
				end
			end
			OP_PB: begin
				if (count_a_q != '0 && count_b_q != CW'(DEPTH)) begin
					head_a_d   = ring_add(head_a_q, CW'(1));
					count_a_d  = count_a_q - CW'(1);
					tcache_a_d = $signed(rdata_a);
					head_b_d   = ring_dec(head_b_q);
					count_b_d  = count_b_q + CW'(1);
					tcache_b_d = tcache_a_q;
					we_b       = 1'b1;
					waddr_b    = head_b_q;
					wdata_b    = tcache_b_q;
					pa         = 1'b1;
				end
			end
			OP_RA, OP_RR, OP_RB: begin
				if ((func_s1 == OP_RA || func_s1 == OP_RR) && two_a) begin
					head_a_d   = ring_add(head_a_q, CW'(1));
					tcache_a_d = $signed(rdata_a);
					we_a       = 1'b1;
					waddr_a    = ring_add(head_a_q, count_a_q);
					pa         = 1'b1;
				end
				if ((func_s1 == OP_RB || func_s1 == OP_RR) && two_b) begin
					head_b_d   = ring_add(head_b_q, CW'(1));
					tcache_b_d = $signed(rdata_b);
					we_b       = 1'b1;
					waddr_b    = ring_add(head_b_q, count_b_q);
					pb         = 1'b1;
				end
			end
			OP_RRA, OP_RRR, OP_RRB: begin
				if ((func_s1 == OP_RRA || func_s1 == OP_RRR) && two_a) begin
					head_a_d   = ring_dec(head_a_q);
					tcache_a_d = $signed(rdata_a);
					we_a       = 1'b1;
					waddr_a    = head_a_q;
					wdata_a    = tcache_a_q;
					pa         = 1'b1;
				end
				if ((func_s1 == OP_RRB || func_s1 == OP_RRR) && two_b) begin
					head_b_d   = ring_dec(head_b_q);
					tcache_b_d = $signed(rdata_b);
					we_b       = 1'b1;
					waddr_b    = head_b_q;
					wdata_b    = tcache_b_q;
					pb         = 1'b1;
				end
			end
			OP_LOAD: begin
				if (count_a_q != CW'(DEPTH)) begin
					we_a      = 1'b1;
					waddr_a   = ring_add(head_a_q, count_a_q);
					wdata_a   = value_s1;
					count_a_d = count_a_q + CW'(1);
					if (count_a_q == '0)
						tcache_a_d = value_s1;
					pa        = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (!exec) begin
			we_a = 1'b0;
			we_b = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			head_a_q    <= '0;
			head_b_q    <= '0;
			count_a_q   <= '0;
			count_b_q   <= '0;
		end else begin
			if (accept)
				pend_q <= 1'b1;
			else if (exec)
				pend_q <= 1'b0;
			if (exec)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (exec) begin
				head_a_q  <= head_a_d;
				head_b_q  <= head_b_d;
				count_a_q <= count_a_d;
				count_b_q <= count_b_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= func;
			value_s1 <= value;
		end
		if (exec) begin
			tcache_a_q  <= tcache_a_d;
			tcache_b_q  <= tcache_b_d;
			performed_q <= pa || pb;
			size_a_q    <= count_a_d;
			size_b_q    <= count_b_d;
			top_a_q     <= (count_a_d == '0) ? '0 : tcache_a_d;
			top_b_q     <= (count_b_d == '0) ? '0 : tcache_b_d;
		end
	end

	assign out_valid = out_valid_q;
	assign performed = performed_q;
	assign size_a    = size_a_q;
	assign size_b    = size_b_q;
	assign top_a     = top_a_q;
	assign top_b     = top_b_q;

endmodule

[test/dual_stack_rotate_checker.sv]
// dual_stack_rotate_checker: tracks both stacks from accepted input words and
// checks every output word against the oldest predicted view
// depends on dsre_pkg
module dual_stack_rotate_checker
	import dsre_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [FW-1:0]        func,
	input  logic signed [DW-1:0] value,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 performed,
	input  logic [CW-1:0]        size_a,
	input  logic [CW-1:0]        size_b,
	input  logic signed [DW-1:0] top_a,
	input  logic signed [DW-1:0] top_b,
	output int                   errors,
	output int                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_A = 0;
	localparam int STACK_B = 1;

	typedef struct {
		logic                 performed;
		logic [CW-1:0]        size_a;
		logic [CW-1:0]        size_b;
		logic signed [DW-1:0] top_a;
		logic signed [DW-1:0] top_b;
	} stack_view_t;

	logic signed [DW-1:0] cells [2][DEPTH];
	int                   head [2];
	int                   fill [2];
	stack_view_t          pending_views [$];

	function automatic int slot_of(input int s, input int k);
		return (head[s] + k) % DEPTH;
	endfunction

	function automatic bit swap_top(input int s);
		logic signed [DW-1:0] t;
		if (fill[s] < 2)
			return 1'b0;
		t = cells[s][slot_of(s, 0)];
		cells[s][slot_of(s, 0)] = cells[s][slot_of(s, 1)];
		cells[s][slot_of(s, 1)] = t;
		return 1'b1;
	endfunction

	function automatic bit move_top(input int src, input int dst);
		logic signed [DW-1:0] v;
		if (fill[src] == 0 || fill[dst] >= DEPTH)
			return 1'b0;
		v = cells[src][head[src]];
		head[src] = (head[src] + 1) % DEPTH;
		fill[src]--;
		head[dst] = (head[dst] + DEPTH - 1) % DEPTH;
		cells[dst][head[dst]] = v;
		fill[dst]++;
		return 1'b1;
	endfunction

	function automatic bit top_to_bottom(input int s);
		logic signed [DW-1:0] v;
		if (fill[s] < 2)
			return 1'b0;
		v = cells[s][head[s]];
		head[s] = (head[s] + 1) % DEPTH;
		cells[s][slot_of(s, fill[s] - 1)] = v;
		return 1'b1;
	endfunction

	function automatic bit bottom_to_top(input int s);
		logic signed [DW-1:0] v;
		if (fill[s] < 2)
			return 1'b0;
		v = cells[s][slot_of(s, fill[s] - 1)];
		head[s] = (head[s] + DEPTH - 1) % DEPTH;
		cells[s][head[s]] = v;
		return 1'b1;
	endfunction

	function automatic bit append_bottom(input int s, input logic signed [DW-1:0] v);
		if (fill[s] >= DEPTH)
			return 1'b0;
		cells[s][slot_of(s, fill[s])] = v;
		fill[s]++;
		return 1'b1;
	endfunction

	function automatic stack_view_t apply_op(input logic [FW-1:0] f,
			input logic signed [DW-1:0] v);
		stack_view_t r;
		bit          ch_a;
		bit          ch_b;
		ch_a = 1'b0;
		ch_b = 1'b0;
		case (f)
			OP_SA:   ch_a = swap_top(STACK_A);
			OP_SB:   ch_b = swap_top(STACK_B);
			OP_SS: begin
				ch_a = swap_top(STACK_A);
				ch_b = swap_top(STACK_B);
			end
			OP_PA:   ch_a = move_top(STACK_B, STACK_A);
			OP_PB:   ch_a = move_top(STACK_A, STACK_B);
			OP_RA:   ch_a = top_to_bottom(STACK_A);
			OP_RB:   ch_b = top_to_bottom(STACK_B);
			OP_RR: begin
				ch_a = top_to_bottom(STACK_A);
				ch_b = top_to_bottom(STACK_B);
			end
			OP_RRA:  ch_a = bottom_to_top(STACK_A);
			OP_RRB:  ch_b = bottom_to_top(STACK_B);
			OP_RRR: begin
				ch_a = bottom_to_top(STACK_A);
				ch_b = bottom_to_top(STACK_B);
			end
			OP_LOAD: ch_a = append_bottom(STACK_A, v);
			default: ;
		endcase
		r.performed = ch_a || ch_b;
		r.size_a    = CW'(fill[STACK_A]);
		r.size_b    = CW'(fill[STACK_B]);
		r.top_a     = (fill[STACK_A] != 0) ? cells[STACK_A][head[STACK_A]] : '0;
		r.top_b     = (fill[STACK_B] != 0) ? cells[STACK_B][head[STACK_B]] : '0;
		return r;
	endfunction

	task automatic check_field(input string name, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			$error("%s expected %0d got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		stack_view_t exp_view;
		if (!arst_n) begin
			head[STACK_A] = 0;
			head[STACK_B] = 0;
			fill[STACK_A] = 0;
			fill[STACK_B] = 0;
			pending_views.delete();
			outstanding = 0;
		end else begin
			if (in_valid && in_ready)
				pending_views.push_back(apply_op(func, value));
			if (out_valid && out_ready) begin
				if (pending_views.size() == 0) begin
					$error("output word with no prediction waiting");
					errors++;
				end else begin
					exp_view = pending_views.pop_front();
					check_field("performed", exp_view.performed, performed);
					check_field("size_a", exp_view.size_a, size_a);
					check_field("size_b", exp_view.size_b, size_b);
					check_field("top_a", exp_view.top_a, top_a);
					check_field("top_b", exp_view.top_b, top_b);
				end
			end
			outstanding = pending_views.size();
		end
	end

	initial begin
		errors      = 0;
		outstanding = 0;
	end

endmodule

[test/tb_dual_stack_rotate_engine.sv]
// tb_dual_stack_rotate_engine: drives operation words into the engine with
// random idling on both sides and reports the verdict
// depends on dsre_pkg, dual_stack_rotate_engine and dual_stack_rotate_checker
module tb_dual_stack_rotate_engine;
	import dsre_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STUCK_LIMIT = 2000;
	localparam int MODE_LEN    = 90;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [FW-1:0]        func;
	logic signed [DW-1:0] value;
	logic                 out_valid;
	logic                 out_ready;
	logic                 performed;
	logic [CW-1:0]        size_a;
	logic [CW-1:0]        size_b;
	logic signed [DW-1:0] top_a;
	logic signed [DW-1:0] top_b;
	int                   errors;
	int                   outstanding;
	int                   words_sent;
	int                   send_idle_pct;
	int                   stall_pct;
	int                   stuck_cycles;

	dual_stack_rotate_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.performed (performed),
		.size_a    (size_a),
		.size_b    (size_b),
		.top_a     (top_a),
		.top_b     (top_b)
	);

	dual_stack_rotate_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.performed   (performed),
		.size_a      (size_a),
		.size_b      (size_b),
		.top_a       (top_a),
		.top_b       (top_b),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// called at a falling edge, returns at the falling edge after the accept
	task automatic send_word(input logic [FW-1:0] f, input logic signed [DW-1:0] v);
		case ((words_sent / MODE_LEN) % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct     = 0;
			end
			1: begin
				send_idle_pct = 69;
				stall_pct     = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct     = 69;
			end
			default: begin
				send_idle_pct = 10;
				stall_pct     = 10;
			end
		endcase
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func     = f;
		value    = v;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_burst(input logic [FW-1:0] f, input int n);
		repeat (n)
			send_word(f, $urandom());
	endtask

	task automatic send_mixed(input int n);
		int r;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 30)
				send_word(OP_LOAD, $urandom());
			else if (r < 35)
				send_word(OP_LOAD + FW'(1) + FW'($urandom_range(3)), $urandom());
			else
				send_word(FW'($urandom_range(OP_RRR)), $urandom());
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		func          = '0;
		value         = '0;
		out_ready     = 1'b0;
		words_sent    = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// most operations and two undefined codes on empty stacks, then loads and operations with a few entries
		send_word(OP_SA, '0);
		send_word(OP_SB, '1);
		send_word(OP_SS, '0);
		send_word(OP_PA, '1);
		send_word(OP_PB, '0);
		send_word(OP_RA, '1);
		send_word(OP_RRA, '0);
		send_word(OP_RRR, '1);
		send_word(OP_LOAD + FW'(1), '0);
		send_word({FW{1'b1}}, '1);
		send_word(OP_LOAD, {1'b1, {(DW-1){1'b0}}});
		send_word(OP_LOAD, {1'b0, {(DW-1){1'b1}}});
		send_word(OP_LOAD, '0);
		send_word(OP_LOAD, '1);
		send_word(OP_PB, '0);
		send_word(OP_SB, '0);
		send_word(OP_PB, '0);
		send_word(OP_SS, '0);
		send_word(OP_RR, '0);
		send_word(OP_RRR, '0);
		send_word(OP_RA, '0);
		send_word(OP_RB, '0);
		send_word(OP_RRA, '0);
		send_word(OP_RRB, '0);
		send_word(OP_PA, '0);

		send_mixed(120);

		// fill a past capacity, then b, so full-side pushes and dropped loads occur
		send_burst(OP_LOAD, DEPTH + 3);
		send_burst(OP_PA, 3);
		send_burst(OP_PB, DEPTH + 3);
		send_burst(OP_LOAD, 10);
		send_burst(OP_PB, 4);

		send_mixed(100);

		in_valid = 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
